// ----- hw/rtl/rsqe_pkg.sv -----
// ----------------------------------------------------------------------------
// rsqe_pkg: shared definitions for the record stack/queue block
// Sizes, action and status codes, and the control structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rsqe_pkg;

  // Store geometry and field widths.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 31;
  localparam int AGE_W  = 7;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  // Action codes carried in the command transaction.
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH    = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_POP     = 2'd2,
    ACT_EXTRACT = 2'd3
  } action_t;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted command
    logic search;  // mark the occupied slots that match (front for pop, key for extract)
    logic apply;   // update the store and load the result register
  } ctrl_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rsqe_in_if.sv -----
// ----------------------------------------------------------------------------
// rsqe_in_if: command channel
// Valid/ready channel that carries one action with its record fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsqe_in_if;
  logic                      valid;
  logic                      ready;
  logic [rsqe_pkg::ACT_W-1:0] action;
  logic [rsqe_pkg::ID_W-1:0]  entry_id;
  logic [rsqe_pkg::AGE_W-1:0] entry_age;

  modport source (output valid, output action, output entry_id, output entry_age,
                  input ready);
  modport sink   (input valid, input action, input entry_id, input entry_age,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rsqe_out_if.sv -----
// ----------------------------------------------------------------------------
// rsqe_out_if: result channel
// Valid/ready channel that carries one status with the removed record.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsqe_out_if;
  logic                       valid;
  logic                       ready;
  logic [rsqe_pkg::STAT_W-1:0] status;
  logic [rsqe_pkg::ID_W-1:0]   out_id;
  logic [rsqe_pkg::AGE_W-1:0]  out_age;

  modport source (output valid, output status, output out_id, output out_age,
                  input ready);
  modport sink   (input valid, input status, input out_id, input out_age,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rsqe_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsqe_ctrl: sequencing state machine
// Steps each command through capture, search and apply, and owns the
// valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsqe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  wire logic                res_ready,
  output logic                     res_valid,
  output rsqe_pkg::ctrl_cmd_t      ctl
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_APPLY  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // The result register is free when empty or being drained this cycle.
  logic res_free;
  assign res_free = !res_valid || res_ready;

  // Command strobes for the datapath.
  assign cmd_ready  = (state == S_IDLE);
  assign ctl.load   = (state == S_IDLE) && cmd_valid;
  assign ctl.search = (state == S_SEARCH);
  assign ctl.apply  = (state == S_APPLY) && res_free;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (res_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.apply) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rsqe_datapath.sv -----
// ----------------------------------------------------------------------------
// rsqe_datapath: record store, search and shift network
// Holds the ordered slots, registers which occupied slots match the key (the
// front slot for a pop), then shifts the store and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsqe_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rsqe_pkg::ctrl_cmd_t          ctl,
  input  wire logic [rsqe_pkg::ACT_W-1:0]   action,
  input  wire logic [rsqe_pkg::ID_W-1:0]    entry_id,
  input  wire logic [rsqe_pkg::AGE_W-1:0]   entry_age,
  output logic [rsqe_pkg::STAT_W-1:0]       status,
  output logic [rsqe_pkg::ID_W-1:0]         out_id,
  output logic [rsqe_pkg::AGE_W-1:0]        out_age,
  output rsqe_pkg::dp_status_t              dp_stat
);

  // Captured command.
  rsqe_pkg::action_t           act_q;
  logic [rsqe_pkg::ID_W-1:0]   key_q;
  logic [rsqe_pkg::AGE_W-1:0]  age_q;

  // Slot cells; slot 0 is the front.
  logic [rsqe_pkg::ID_W-1:0]   slot_id  [rsqe_pkg::DEPTH];
  logic [rsqe_pkg::AGE_W-1:0]  slot_age [rsqe_pkg::DEPTH];
  logic [rsqe_pkg::CNT_W-1:0]  count;

  // Per-slot match flags from the search cycle.
  logic [rsqe_pkg::DEPTH-1:0]  match;
  logic [rsqe_pkg::DEPTH-1:0]  match_next;

  logic [rsqe_pkg::DEPTH-1:0]  ge_mask;
  logic [rsqe_pkg::DEPTH-1:0]  first;
  logic [rsqe_pkg::ID_W-1:0]   rem_id;
  logic [rsqe_pkg::AGE_W-1:0]  rem_age;
  logic                        hit;
  logic                        full;

  assign dp_stat.count = count;
  assign full = (count == rsqe_pkg::CNT_W'(rsqe_pkg::DEPTH));
  assign hit  = |match;

  // Search: a pop matches the front slot, an extract every slot whose id
  // equals the key. Only occupied slots take part.
  always_comb begin
    for (int i = 0; i < rsqe_pkg::DEPTH; i++) begin
      if (rsqe_pkg::CNT_W'(i) < count) begin
        if (act_q == rsqe_pkg::ACT_POP) begin
          match_next[i] = (i == 0);
        end else begin
          match_next[i] = (act_q == rsqe_pkg::ACT_EXTRACT) && (slot_id[i] == key_q);
        end
      end else begin
        match_next[i] = 1'b0;
      end
    end
  end

  // Slots at or behind the first match take the value of their successor.
  always_comb begin
    for (int i = 0; i < rsqe_pkg::DEPTH; i++) begin
      ge_mask[i] = |(match & ({rsqe_pkg::DEPTH{1'b1}} >> (rsqe_pkg::DEPTH - 1 - i)));
    end
  end

  assign first = match & ~(ge_mask << 1);

  // Select the removed record with an AND-OR over the one-hot first match.
  always_comb begin
    rem_id  = '0;
    rem_age = '0;
    for (int i = 0; i < rsqe_pkg::DEPTH; i++) begin
      rem_id  = rem_id  | ({rsqe_pkg::ID_W{first[i]}}  & slot_id[i]);
      rem_age = rem_age | ({rsqe_pkg::AGE_W{first[i]}} & slot_age[i]);
    end
  end

  // Command capture and search result.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      act_q <= rsqe_pkg::action_t'(action);
      key_q <= entry_id;
      age_q <= entry_age;
    end
    if (ctl.search) begin
      match <= match_next;
    end
  end

  // Store update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.apply) begin
      case (act_q)
        rsqe_pkg::ACT_PUSH, rsqe_pkg::ACT_APPEND: begin
          if (!full) count <= count + rsqe_pkg::CNT_W'(1);
        end
        rsqe_pkg::ACT_POP, rsqe_pkg::ACT_EXTRACT: begin
          if (hit) count <= count - rsqe_pkg::CNT_W'(1);
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      out_id  <= '0;
      out_age <= '0;
      case (act_q)
        rsqe_pkg::ACT_PUSH: begin
          if (full) begin
            status <= rsqe_pkg::ST_FULL;
          end else begin
            status      <= rsqe_pkg::ST_OK;
            slot_id[0]  <= key_q;
            slot_age[0] <= age_q;
            for (int i = 1; i < rsqe_pkg::DEPTH; i++) begin
              slot_id[i]  <= slot_id[i-1];
              slot_age[i] <= slot_age[i-1];
            end
          end
        end
        rsqe_pkg::ACT_APPEND: begin
          if (full) begin
            status <= rsqe_pkg::ST_FULL;
          end else begin
            status                              <= rsqe_pkg::ST_OK;
            slot_id[count[rsqe_pkg::IDX_W-1:0]]  <= key_q;
            slot_age[count[rsqe_pkg::IDX_W-1:0]] <= age_q;
          end
        end
        rsqe_pkg::ACT_POP, rsqe_pkg::ACT_EXTRACT: begin
          if (hit) begin
            status  <= rsqe_pkg::ST_OK;
            out_id  <= rem_id;
            out_age <= rem_age;
            for (int i = 0; i < rsqe_pkg::DEPTH - 1; i++) begin
              if (ge_mask[i]) begin
                slot_id[i]  <= slot_id[i+1];
                slot_age[i] <= slot_age[i+1];
              end
            end
          end else begin
            status <= rsqe_pkg::ST_NONE;
          end
        end
        default: begin
          status <= rsqe_pkg::ST_NONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/record_stack_queue_extract.sv -----
// A command passes through the capture, search and apply states; a result is
// registered when apply is taken, and no new command is accepted until then.
// The controller sets this sequence; apply waits while the result is unread.
// Reset clears the record count and the controller; slot contents are left
// as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// record_stack_queue_extract: ordered record store with push, append,
// pop and extract-by-id, built as a controller plus a datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module record_stack_queue_extract (
  input  wire logic   clk,
  input  wire logic   rst,
  rsqe_in_if.sink     cmd,
  rsqe_out_if.source  res
);

  rsqe_pkg::ctrl_cmd_t  ctl;
  rsqe_pkg::dp_status_t dp_stat;

  // Sequencing.
  rsqe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_ready (res.ready),
    .res_valid (res.valid),
    .ctl       (ctl)
  );

  // Store and result register.
  rsqe_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .action    (cmd.action),
    .entry_id  (cmd.entry_id),
    .entry_age (cmd.entry_age),
    .status    (res.status),
    .out_id    (res.out_id),
    .out_age   (res.out_age),
    .dp_stat   (dp_stat)
  );

`ifndef SYNTHESIS
  // Only one command is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command accepted while another is in flight");

  // The record count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    dp_stat.count <= rsqe_pkg::CNT_W'(rsqe_pkg::DEPTH))
    else $error("record count exceeds depth");

  // Every applied command presents a result in the next cycle.
  a_apply_result: assert property (@(posedge clk) disable iff (rst)
    ctl.apply |=> res.valid)
    else $error("applied command produced no result");
`endif

endmodule

`default_nettype wire

// ----- bench/record_stack_queue_extract_tb.sv -----
// ----------------------------------------------------------------------------
// record_stack_queue_extract_tb: self-checking bench for the record store
// Drives push, append, pop and extract-by-id commands over the command
// channel, keeps a shadow copy of the ordered store to predict each result,
// and compares every result transaction field by field as it is accepted.
// ----------------------------------------------------------------------------

module record_stack_queue_extract_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD  = 60;
  localparam int SEGMENTS   = 20;
  localparam int SEG_ITEMS  = 100;

  // One predicted result transaction.
  typedef struct packed {
    logic [rsqe_pkg::STAT_W-1:0] status;
    logic [rsqe_pkg::ID_W-1:0]   id;
    logic [rsqe_pkg::AGE_W-1:0]  age;
  } record_result_t;

  // Shadow copy of the ordered store and the results it predicts.
  class expected_record_store;
    logic [rsqe_pkg::ID_W-1:0]  ids [rsqe_pkg::DEPTH];
    logic [rsqe_pkg::AGE_W-1:0] ages [rsqe_pkg::DEPTH];
    int                         fill = 0;
    record_result_t             pending_results [$];
    int                         mismatch_count = 0;

    // Take the record at pos out of the store and close the gap.
    function void remove_record(int pos, output record_result_t res);
      res.status = rsqe_pkg::ST_OK;
      res.id     = ids[pos];
      res.age    = ages[pos];
      for (int i = pos; i + 1 < fill; i++) begin
        ids[i]  = ids[i + 1];
        ages[i] = ages[i + 1];
      end
      fill--;
    endfunction

    // Apply one accepted command and queue the result it must produce.
    function void note_command(rsqe_pkg::action_t act, logic [rsqe_pkg::ID_W-1:0] key,
                               logic [rsqe_pkg::AGE_W-1:0] age);
      record_result_t res;
      int             pos;
      res = '{status: rsqe_pkg::ST_NONE, id: '0, age: '0};
      case (act)
        rsqe_pkg::ACT_PUSH, rsqe_pkg::ACT_APPEND: begin
          if (fill >= rsqe_pkg::DEPTH) begin
            res.status = rsqe_pkg::ST_FULL;
          end else begin
            if (act == rsqe_pkg::ACT_PUSH) begin
              for (int i = fill; i > 0; i--) begin
                ids[i]  = ids[i - 1];
                ages[i] = ages[i - 1];
              end
              ids[0]  = key;
              ages[0] = age;
            end else begin
              ids[fill]  = key;
              ages[fill] = age;
            end
            fill++;
            res.status = rsqe_pkg::ST_OK;
          end
        end
        rsqe_pkg::ACT_POP: begin
          if (fill > 0) remove_record(0, res);
        end
        default: begin
          // The match nearest the front wins when ids repeat.
          pos = -1;
          for (int i = 0; i < fill; i++) begin
            if (pos < 0 && ids[i] == key) pos = i;
          end
          if (pos >= 0) remove_record(pos, res);
        end
      endcase
      pending_results.push_back(res);
    endfunction

    // Compare one accepted result transaction with the oldest prediction.
    function void check_result(logic [rsqe_pkg::STAT_W-1:0] status,
                               logic [rsqe_pkg::ID_W-1:0] id,
                               logic [rsqe_pkg::AGE_W-1:0] age);
      record_result_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result status=%0d id=%0h age=%0d", $time, status, id, age);
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        mismatch_count++;
        $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
      end
      if (id !== want.id) begin
        mismatch_count++;
        $display("%0t: out_id expected %0h, actual %0h", $time, want.id, id);
      end
      if (age !== want.age) begin
        mismatch_count++;
        $display("%0t: out_age expected %0d, actual %0d", $time, want.age, age);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rsqe_in_if  cmd_if ();
  rsqe_out_if res_if ();

  expected_record_store shadow_store = new;

  int tx_stall_pct = 0;
  int rx_stall_pct = 0;
  bit hold_request = 1'b0;
  bit quiet_finish = 1'b0;

  record_stack_queue_extract u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if.sink),
    .res (res_if.source)
  );

  // Free-running 50 MHz clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Track every accepted transaction on both channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready)
        shadow_store.check_result(res_if.status, res_if.out_id, res_if.out_age);
      if (cmd_if.valid && cmd_if.ready)
        shadow_store.note_command(rsqe_pkg::action_t'(cmd_if.action), cmd_if.entry_id,
                                  cmd_if.entry_age);
    end
  end

  // Result side: random stall bursts, one long hold on request.
  initial begin : result_sink
    int hold;
    res_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold = 0;
        res_if.ready <= 1'b0;
        while (hold < LONG_HOLD) begin
          @(posedge clk);
          hold++;
        end
      end else if (!quiet_finish && $urandom_range(0, 99) < rx_stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // End the run if neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("record_stack_queue_extract_tb: errors");
    $finish;
  end

  // Often tiny ids so that duplicates and hits are common.
  function automatic logic [rsqe_pkg::ID_W-1:0] random_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rsqe_pkg::ID_W'($urandom_range(0, 7));
      4:          return {rsqe_pkg::ID_W{1'b1}};
      default:    return rsqe_pkg::ID_W'($urandom);
    endcase
  endfunction

  // Offer one command transaction, with an optional gap first.
  task automatic send_command(input rsqe_pkg::action_t act,
                              input logic [rsqe_pkg::ID_W-1:0] key,
                              input logic [rsqe_pkg::AGE_W-1:0] age);
    if (!quiet_finish && $urandom_range(0, 99) < tx_stall_pct) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.entry_id  <= rsqe_pkg::ID_W'($urandom);
      cmd_if.entry_age <= rsqe_pkg::AGE_W'($urandom);
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.action    <= act;
    cmd_if.entry_id  <= key;
    cmd_if.entry_age <= age;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Stop offering until every predicted result has been seen.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (shadow_store.pending_results.size() != 0);
  endtask

  // One random command; fill_bias is the percent chance of an insert.
  task automatic random_command(input int fill_bias);
    rsqe_pkg::action_t          act;
    logic [rsqe_pkg::ID_W-1:0]  key;
    logic [rsqe_pkg::AGE_W-1:0] age;
    if ($urandom_range(0, 99) < fill_bias)
      act = $urandom_range(0, 1) ? rsqe_pkg::ACT_APPEND : rsqe_pkg::ACT_PUSH;
    else
      act = $urandom_range(0, 1) ? rsqe_pkg::ACT_EXTRACT : rsqe_pkg::ACT_POP;
    key = random_key();
    age = rsqe_pkg::AGE_W'($urandom);
    // Most searches aim at a record that is really there.
    if (act == rsqe_pkg::ACT_EXTRACT && shadow_store.fill > 0 &&
        $urandom_range(0, 99) < 60)
      key = shadow_store.ids[$urandom_range(0, shadow_store.fill - 1)];
    send_command(act, key, age);
  endtask

  // Main sequence.
  initial begin
    int bias;
    rst              = 1'b1;
    cmd_if.valid     = 1'b0;
    cmd_if.action    = rsqe_pkg::ACT_PUSH;
    cmd_if.entry_id  = '0;
    cmd_if.entry_age = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, extremes, duplicates, middle hit, full store.
    send_command(rsqe_pkg::ACT_POP, '0, '0);
    send_command(rsqe_pkg::ACT_EXTRACT, {rsqe_pkg::ID_W{1'b1}}, '0);
    send_command(rsqe_pkg::ACT_PUSH, '0, '0);
    send_command(rsqe_pkg::ACT_APPEND, {rsqe_pkg::ID_W{1'b1}}, {rsqe_pkg::AGE_W{1'b1}});
    send_command(rsqe_pkg::ACT_PUSH, rsqe_pkg::ID_W'(77), rsqe_pkg::AGE_W'(3));
    send_command(rsqe_pkg::ACT_APPEND, rsqe_pkg::ID_W'(77), rsqe_pkg::AGE_W'(100));
    send_command(rsqe_pkg::ACT_EXTRACT, rsqe_pkg::ID_W'(77), {rsqe_pkg::AGE_W{1'b1}});
    send_command(rsqe_pkg::ACT_EXTRACT, rsqe_pkg::ID_W'(12345), '0);
    send_command(rsqe_pkg::ACT_EXTRACT, {rsqe_pkg::ID_W{1'b1}}, '0);
    send_command(rsqe_pkg::ACT_POP, '0, '0);
    for (int i = 0; i < rsqe_pkg::DEPTH - 1; i++)
      send_command(i % 2 ? rsqe_pkg::ACT_APPEND : rsqe_pkg::ACT_PUSH, random_key(),
                   rsqe_pkg::AGE_W'($urandom));
    send_command(rsqe_pkg::ACT_PUSH, rsqe_pkg::ID_W'(9), rsqe_pkg::AGE_W'(9));
    send_command(rsqe_pkg::ACT_APPEND, rsqe_pkg::ID_W'(9), rsqe_pkg::AGE_W'(9));

    // Random segments, each with its own mix and idling level.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0:       bias = 80;
        1:       bias = 50;
        default: bias = 25;
      endcase
      tx_stall_pct = $urandom_range(0, 2) * 15;
      rx_stall_pct = $urandom_range(0, 2) * 15;
      if (seg == 3) begin
        // Sender keeps offering while the result side holds off.
        tx_stall_pct = 0;
        hold_request = 1'b1;
      end
      if (seg == 6 || seg == 12) wait_drained();
      if (seg >= SEGMENTS - 2) quiet_finish = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) random_command(bias);
    end

    // Let the last results arrive before the final report.
    wait_drained();
    repeat (8) @(posedge clk);
    if (shadow_store.mismatch_count == 0 && shadow_store.pending_results.size() == 0)
      $display("record_stack_queue_extract_tb: clean");
    else
      $display("record_stack_queue_extract_tb: errors");
    $finish;
  end

endmodule
